### hw/rtl/plht_pkg.sv
// package: request codes, controller states and control structs for the polyline hit test
`default_nettype none
package plht_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam int MW = 67;
    localparam int MSW = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_LD0,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_DEC,
        ST_MUL,
        ST_CMP,
        ST_RES
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic query;
        logic rd;
        logic load_first;
        logic diff;
        logic prod;
        logic sum;
        logic mul_init;
        logic mul_step;
        logic res_load;
        logic res_hit;
    } cmd_t;

    typedef struct packed {
        logic few;
        logic last;
        logic dec_near;
        logic dec_hit;
        logic mul_last;
        logic cross_hit;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

### hw/rtl/plht_ram.sv
// generic single write port ram with registered read
`default_nettype none
module plht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/plht_ctrl.sv
// controller state machine for the polyline hit test
`default_nettype none
module plht_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       req_type,
    input  wire plht_pkg::sts_t   sts,
    output plht_pkg::cmd_t        cmd
);

    plht_pkg::state_t state_reg, state_next;
    logic hit_reg, hit_next;
    logic acc;

    assign in_ready = (state_reg == plht_pkg::ST_IDLE);
    assign acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plht_pkg::ST_IDLE;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        case (state_reg)
            plht_pkg::ST_IDLE:
            begin
                if (acc && req_type == plht_pkg::REQ_QUERY)
                begin
                    hit_next = 1'b0;
                    state_next = sts.few ? plht_pkg::ST_RES : plht_pkg::ST_RD0;
                end
            end
            plht_pkg::ST_RD0: state_next = plht_pkg::ST_LD0;
            plht_pkg::ST_LD0: state_next = plht_pkg::ST_DIFF;
            plht_pkg::ST_DIFF: state_next = plht_pkg::ST_PROD;
            plht_pkg::ST_PROD: state_next = plht_pkg::ST_SUM;
            plht_pkg::ST_SUM: state_next = plht_pkg::ST_DEC;
            plht_pkg::ST_DEC:
            begin
                if (!sts.dec_near)
                begin
                    state_next = plht_pkg::ST_MUL;
                end
                else if (sts.dec_hit)
                begin
                    hit_next = 1'b1;
                    state_next = plht_pkg::ST_RES;
                end
                else if (sts.last)
                begin
                    state_next = plht_pkg::ST_RES;
                end
                else
                begin
                    state_next = plht_pkg::ST_DIFF;
                end
            end
            plht_pkg::ST_MUL:
            begin
                if (sts.mul_last)
                begin
                    state_next = plht_pkg::ST_CMP;
                end
            end
            plht_pkg::ST_CMP:
            begin
                if (sts.cross_hit)
                begin
                    hit_next = 1'b1;
                    state_next = plht_pkg::ST_RES;
                end
                else if (sts.last)
                begin
                    state_next = plht_pkg::ST_RES;
                end
                else
                begin
                    state_next = plht_pkg::ST_DIFF;
                end
            end
            plht_pkg::ST_RES:
            begin
                if (!sts.out_busy)
                begin
                    state_next = plht_pkg::ST_IDLE;
                end
            end
            default: state_next = plht_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            plht_pkg::ST_IDLE:
            begin
                cmd.clear  = acc && req_type == plht_pkg::REQ_CLEAR;
                cmd.append = acc && req_type == plht_pkg::REQ_APPEND;
                cmd.query  = acc && req_type == plht_pkg::REQ_QUERY;
            end
            plht_pkg::ST_RD0: cmd.rd = 1'b1;
            plht_pkg::ST_LD0:
            begin
                cmd.load_first = 1'b1;
                cmd.rd = 1'b1;
            end
            plht_pkg::ST_DIFF: cmd.diff = 1'b1;
            plht_pkg::ST_PROD: cmd.prod = 1'b1;
            plht_pkg::ST_SUM: cmd.sum = 1'b1;
            plht_pkg::ST_DEC:
            begin
                cmd.mul_init = !sts.dec_near;
                cmd.rd = sts.dec_near && !sts.dec_hit && !sts.last;
            end
            plht_pkg::ST_MUL: cmd.mul_step = 1'b1;
            plht_pkg::ST_CMP: cmd.rd = !sts.cross_hit && !sts.last;
            plht_pkg::ST_RES:
            begin
                cmd.res_load = !sts.out_busy;
                cmd.res_hit  = hit_reg;
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/plht_dp.sv
// datapath: vertex store, segment distance arithmetic, serial wide multiplier, result register
`default_nettype none
module plht_dp #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic [30:0]        tolerance,
    input  wire plht_pkg::cmd_t     cmd,
    output plht_pkg::sts_t          sts,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit,
    output logic                    vertices_dropped
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int MW = plht_pkg::MW;
    localparam int MSW = plht_pkg::MSW;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          drop_reg;
    logic          full;
    logic [63:0]   rd_data;

    logic signed [31:0] px_reg, py_reg;
    logic [61:0]        tol2_reg;
    logic signed [31:0] x1_reg, y1_reg;
    logic signed [31:0] cx, cy;
    logic signed [32:0] dx_reg, dy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [65:0] p_axdx_reg, p_aydy_reg, p_axdy_reg, p_aydx_reg;
    logic signed [65:0] p_dx2_reg, p_dy2_reg, p_ax2_reg, p_ay2_reg, p_bx2_reg, p_by2_reg;
    logic signed [MW-1:0] dot_reg, cr_reg;
    logic [MW-1:0]        len2_reg, d1_reg, d2_reg;
    logic [MW-1:0]        tol2_ext, cr_mag;
    logic                 near, d1_ok, d2_ok, far;

    logic [2*MW-1:0] mcand_a_reg, mcand_b_reg, acc_a_reg, acc_b_reg;
    logic [MW-1:0]   mplier_a_reg, mplier_b_reg;
    logic [MSW-1:0]  mcnt_reg;

    logic out_valid_reg, hit_reg, dropped_reg;

    assign full = (count_reg == CW'(MAX_VERTICES));

    plht_ram #(
        .WIDTH (64),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.append && !full),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({point_x, point_y}),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.query)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cx = rd_data[63:32];
    assign cy = rd_data[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            tol2_reg <= 62'(tolerance) * 62'(tolerance);
        end
        if (cmd.load_first)
        begin
            x1_reg <= cx;
            y1_reg <= cy;
        end
        if (cmd.diff)
        begin
            x1_reg <= cx;
            y1_reg <= cy;
            dx_reg <= 33'(cx) - 33'(x1_reg);
            dy_reg <= 33'(cy) - 33'(y1_reg);
            ax_reg <= 33'(px_reg) - 33'(x1_reg);
            ay_reg <= 33'(py_reg) - 33'(y1_reg);
            bx_reg <= 33'(px_reg) - 33'(cx);
            by_reg <= 33'(py_reg) - 33'(cy);
        end
        if (cmd.prod)
        begin
            p_axdx_reg <= ax_reg * dx_reg;
            p_aydy_reg <= ay_reg * dy_reg;
            p_axdy_reg <= ax_reg * dy_reg;
            p_aydx_reg <= ay_reg * dx_reg;
            p_dx2_reg  <= dx_reg * dx_reg;
            p_dy2_reg  <= dy_reg * dy_reg;
            p_ax2_reg  <= ax_reg * ax_reg;
            p_ay2_reg  <= ay_reg * ay_reg;
            p_bx2_reg  <= bx_reg * bx_reg;
            p_by2_reg  <= by_reg * by_reg;
        end
        if (cmd.sum)
        begin
            dot_reg  <= MW'(p_axdx_reg) + MW'(p_aydy_reg);
            cr_reg   <= MW'(p_axdy_reg) - MW'(p_aydx_reg);
            len2_reg <= {1'b0, p_dx2_reg[65:0]} + {1'b0, p_dy2_reg[65:0]};
            d1_reg   <= {1'b0, p_ax2_reg[65:0]} + {1'b0, p_ay2_reg[65:0]};
            d2_reg   <= {1'b0, p_bx2_reg[65:0]} + {1'b0, p_by2_reg[65:0]};
        end
        if (cmd.mul_init)
        begin
            mcand_a_reg  <= {{MW{1'b0}}, cr_mag};
            mplier_a_reg <= cr_mag;
            mcand_b_reg  <= {{MW{1'b0}}, len2_reg};
            mplier_b_reg <= tol2_ext;
            acc_a_reg    <= '0;
            acc_b_reg    <= '0;
            mcnt_reg     <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mplier_a_reg[0])
            begin
                acc_a_reg <= acc_a_reg + mcand_a_reg;
            end
            if (mplier_b_reg[0])
            begin
                acc_b_reg <= acc_b_reg + mcand_b_reg;
            end
            mcand_a_reg  <= mcand_a_reg << 1;
            mcand_b_reg  <= mcand_b_reg << 1;
            mplier_a_reg <= mplier_a_reg >> 1;
            mplier_b_reg <= mplier_b_reg >> 1;
            mcnt_reg     <= mcnt_reg + MSW'(1);
        end
        if (cmd.res_load)
        begin
            hit_reg     <= cmd.res_hit;
            dropped_reg <= drop_reg;
        end
    end

    assign tol2_ext = {{(MW-62){1'b0}}, tol2_reg};
    assign cr_mag   = cr_reg[MW-1] ? MW'(-cr_reg) : MW'(cr_reg);
    assign near     = (len2_reg == '0) || dot_reg[MW-1] || (dot_reg == '0);
    assign far      = $unsigned(dot_reg) >= len2_reg;
    assign d1_ok    = d1_reg <= tol2_ext;
    assign d2_ok    = d2_reg <= tol2_ext;

    always_comb
    begin
        sts.few       = count_reg < CW'(2);
        sts.last      = idx_reg == count_reg;
        sts.dec_near  = near || far;
        sts.dec_hit   = near ? d1_ok : d2_ok;
        sts.mul_last  = mcnt_reg == MSW'(MW - 1);
        sts.cross_hit = acc_a_reg <= acc_b_reg;
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign vertices_dropped = dropped_reg;

endmodule
`default_nettype wire

### hw/rtl/polyline_point_hit_test_core.sv
// top level of the polyline point hit test
// clear and append are taken in idle; a query loads the first vertex in RD0 and LD0, then runs
// DIFF, PROD, SUM, DEC per segment, and MUL, CMP when the perpendicular test runs the 67-step serial multiplier
// segments are read one per pass from the vertex ram's registered read port; the walk stops at a hit
// the result sits in an output register; requests wait until idle, and a result waits while the old one is held
// asynchronous active-low reset empties the polyline and clears the drop flag
`default_nettype none
module polyline_point_hit_test_core #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic [30:0]        tolerance,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit,
    output logic                    vertices_dropped
);

    plht_pkg::cmd_t cmd;
    plht_pkg::sts_t sts;

    plht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    plht_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .point_x          (point_x),
        .point_y          (point_y),
        .tolerance        (tolerance),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .vertices_dropped (vertices_dropped)
    );

endmodule
`default_nettype wire
